### design/htat_pkg.sv
// Shared types and constants for the host traffic accounting table.
// Used by the front, queue, table, back and checker modules; depends on nothing.
package htat_pkg;

  localparam int SLOT_W   = 5;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int TICKS_W  = 24;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 24'd60000;

  localparam logic OP_PKT  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_PKT   = 2'd0;
  localparam logic [1:0] KIND_SRC   = 2'd1;
  localparam logic [1:0] KIND_DST   = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam logic [1:0] ST_MATCH  = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic        is_dump;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [31:0] dst_ip;
    logic [47:0] dst_mac;
    logic [15:0] len;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              last;
    logic [1:0]        src_status;
    logic [1:0]        dst_status;
    logic [SLOT_W-1:0] src_slot;
    logic [SLOT_W-1:0] dst_slot;
    logic [SLOT_W-1:0] entry_slot;
    logic [31:0]       entry_ip;
    logic [47:0]       entry_mac;
    logic [31:0]       entry_bytes;
  } result_t;

  typedef struct packed {
    logic cmp;
    logic upd;
    logic clr;
    logic sel_hit;
  } tab_ctl_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } tab_res_t;

endpackage

### design/htat_front.sv
// Input side: accepts beats, keeps the window tick counter and the window length
// register, and turns packets and window ends into queue commands. Uses htat_pkg.
module htat_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [175:0]                   s_tdata,
  input  logic [0:0]                     s_tuser,
  input  logic                           cfg_we,
  input  logic [htat_pkg::TICKS_W-1:0]   cfg_wdata,
  input  logic                           q_full,
  output logic                           q_push,
  output htat_pkg::cmd_t                 q_data
);
  import htat_pkg::*;

  logic [TICKS_W-1:0] window_ticks;
  logic [TICKS_W-1:0] window_count;
  logic [TICKS_W-1:0] count_inc;
  logic               accept;
  logic               is_tick;
  logic               win_end;

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign is_tick   = (s_tuser[0] == OP_TICK);
  assign count_inc = window_count + TICKS_W'(1);
  assign win_end   = !(count_inc < window_ticks);
  assign q_push    = accept && (!is_tick || win_end);

  always_comb begin
    q_data.is_dump = is_tick;
    q_data.src_ip  = s_tdata[31:0];
    q_data.src_mac = s_tdata[79:32];
    q_data.dst_ip  = s_tdata[111:80];
    q_data.dst_mac = s_tdata[159:112];
    q_data.len     = s_tdata[175:160];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= TICKS_RESET;
    end else if (cfg_we) begin
      window_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
    end else if (accept && is_tick) begin
      window_count <= win_end ? '0 : count_inc;
    end
  end

endmodule

### design/htat_queue.sv
// Short command queue between the front and the back so each side stalls alone.
// Uses htat_pkg for the command type.
module htat_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  htat_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output htat_pkg::cmd_t head,
  output logic           empty
);
  import htat_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == (QPTR_W+1)'(QDEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### design/htat_table.sv
// One host table: keys compared in parallel into a registered match vector,
// byte totals with a saturating add, and a fill count. Uses htat_pkg.
module htat_table #(
  parameter int TABLE_DEPTH = 32,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  htat_pkg::tab_ctl_t   ctl,
  input  logic [31:0]          key_ip,
  input  logic [47:0]          key_mac,
  input  logic [15:0]          key_len,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic [CNT_W-1:0]     used,
  output htat_pkg::tab_res_t   res,
  output logic [31:0]          rd_ip,
  output logic [47:0]          rd_mac,
  output logic [31:0]          rd_bytes
);
  import htat_pkg::*;

  logic [31:0]            ip_mem  [TABLE_DEPTH];
  logic [47:0]            mac_mem [TABLE_DEPTH];
  logic [31:0]            tot_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;
  logic [31:0]            k_ip;
  logic [47:0]            k_mac;
  logic [15:0]            k_len;
  logic                   hit;
  logic                   full;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       used_idx;
  logic [IDX_W-1:0]       addr;
  logic [32:0]            sum;
  logic [31:0]            sat;

  assign hit      = |match;
  assign full     = (used == CNT_W'(TABLE_DEPTH));
  assign used_idx = used[IDX_W-1:0];
  assign addr     = ctl.sel_hit ? hit_idx : rd_idx;
  assign rd_ip    = ip_mem[addr];
  assign rd_mac   = mac_mem[addr];
  assign rd_bytes = tot_mem[addr];
  assign sum      = {1'b0, rd_bytes} + {17'd0, k_len};
  assign sat      = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  // Keys are unique in a table, so at most one match bit is set.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (hit) begin
      res.status = ST_MATCH;
      res.slot   = SLOT_W'(hit_idx);
    end else if (full) begin
      res.status = ST_FULL;
      res.slot   = '0;
    end else begin
      res.status = ST_INSERT;
      res.slot   = SLOT_W'(used_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (ctl.clr) begin
      used <= '0;
    end else if (ctl.upd && !hit && !full) begin
      used <= used + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      k_ip  <= key_ip;
      k_mac <= key_mac;
      k_len <= key_len;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        match[i] <= (CNT_W'(i) < used) && (ip_mem[i] == key_ip) && (mac_mem[i] == key_mac);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      if (hit) begin
        tot_mem[hit_idx] <= sat;
      end else if (!full) begin
        ip_mem[used_idx]  <= k_ip;
        mac_mem[used_idx] <= k_mac;
        tot_mem[used_idx] <= {16'd0, k_len};
      end
    end
  end

endmodule

### design/htat_back.sv
// Execution side: runs packet lookups and window dumps on the two tables and
// holds the output register. Uses htat_pkg and htat_table.
module htat_back #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  htat_pkg::cmd_t      q_head,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                out_ready,
  output logic                out_valid,
  output htat_pkg::result_t   out_res
);
  import htat_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_DSRC = 4'b0100,
    S_DDST = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic [CNT_W-1:0] idx_inc;
  tab_ctl_t         ctl;
  logic             out_free;
  logic             load;
  result_t          res_next;
  logic [CNT_W-1:0] s_used;
  logic [CNT_W-1:0] d_used;
  tab_res_t         s_res;
  tab_res_t         d_res;
  logic [31:0]      s_ip;
  logic [47:0]      s_mac;
  logic [31:0]      s_bytes;
  logic [31:0]      d_ip;
  logic [47:0]      d_mac;
  logic [31:0]      d_bytes;

  assign out_free = !out_valid || out_ready;
  assign idx_inc  = idx + CNT_W'(1);

  htat_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_src (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .key_ip   (q_head.src_ip),
    .key_mac  (q_head.src_mac),
    .key_len  (q_head.len),
    .rd_idx   (idx[IDX_W-1:0]),
    .used     (s_used),
    .res      (s_res),
    .rd_ip    (s_ip),
    .rd_mac   (s_mac),
    .rd_bytes (s_bytes)
  );

  htat_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_dst (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .key_ip   (q_head.dst_ip),
    .key_mac  (q_head.dst_mac),
    .key_len  (q_head.len),
    .rd_idx   (idx[IDX_W-1:0]),
    .used     (d_used),
    .res      (d_res),
    .rd_ip    (d_ip),
    .rd_mac   (d_mac),
    .rd_bytes (d_bytes)
  );

  always_comb begin
    state_next = state;
    idx_next   = idx;
    ctl        = '0;
    q_pop      = 1'b0;
    load       = 1'b0;
    res_next   = '0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.is_dump) begin
            idx_next   = '0;
            state_next = S_DSRC;
          end else begin
            ctl.cmp    = 1'b1;
            state_next = S_UPD;
          end
        end
      end
      S_UPD: begin
        ctl.sel_hit = 1'b1;
        if (out_free) begin
          ctl.upd             = 1'b1;
          load                = 1'b1;
          res_next.kind       = KIND_PKT;
          res_next.last       = 1'b1;
          res_next.src_status = s_res.status;
          res_next.dst_status = d_res.status;
          res_next.src_slot   = s_res.slot;
          res_next.dst_slot   = d_res.slot;
          state_next          = S_IDLE;
        end
      end
      S_DSRC: begin
        if (!(idx < s_used)) begin
          idx_next   = '0;
          state_next = S_DDST;
        end else if (out_free) begin
          load                 = 1'b1;
          res_next.kind        = KIND_SRC;
          res_next.last        = (idx_inc == s_used) && (d_used == '0);
          res_next.entry_slot  = SLOT_W'(idx[IDX_W-1:0]);
          res_next.entry_ip    = s_ip;
          res_next.entry_mac   = s_mac;
          res_next.entry_bytes = s_bytes;
          idx_next             = idx_inc;
        end
      end
      S_DDST: begin
        if (idx < d_used) begin
          if (out_free) begin
            load                 = 1'b1;
            res_next.kind        = KIND_DST;
            res_next.last        = (idx_inc == d_used);
            res_next.entry_slot  = SLOT_W'(idx[IDX_W-1:0]);
            res_next.entry_ip    = d_ip;
            res_next.entry_mac   = d_mac;
            res_next.entry_bytes = d_bytes;
            idx_next             = idx_inc;
          end
        end else if ((s_used == '0) && (d_used == '0)) begin
          if (out_free) begin
            load          = 1'b1;
            res_next.kind = KIND_EMPTY;
            res_next.last = 1'b1;
            ctl.clr       = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          ctl.clr    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res_next;
    end
  end

endmodule

### design/host_traffic_accounting_table.sv
// Top level of the host traffic accounting table: front, command queue and back.
// Uses htat_pkg, htat_front, htat_queue and htat_back.
//
//   channel  direction  tdata                                   tuser   tlast
//   s_*      in         source/dest IP and MAC, frame_len       opcode  -
//   m_*      out        status, slots, reported entry           kind    last
//   cfg_*    in         window_ticks write                      -       -
//
// In the back a packet gets a parallel compare into a registered match
// vector, then the update of both tables and the result beat. A window end
// reports each source entry, then each destination entry, or an empty beat
// if both tables are empty. A tick inside a window is absorbed by the front.
// Reset is synchronous and needs no clearing pass; tables empty by fill count.
// A four-entry queue lets the front take beats while the output is stalled.
module host_traffic_accounting_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // source_ip, source_mac, dest_ip, dest_mac, frame_len
  input  logic [175:0]                  s_tdata,
  // opcode
  input  logic [0:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // src_status, dst_status, src_slot, dst_slot, entry_slot, entry_ip,
  // entry_mac, entry_bytes, zero fill
  output logic [135:0]                  m_tdata,
  // kind
  output logic [1:0]                    m_tuser,
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [htat_pkg::TICKS_W-1:0]  cfg_wdata
);
  import htat_pkg::*;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  cmd_t    q_in;
  cmd_t    q_head;
  result_t res;

  htat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  htat_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  htat_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_res   (res)
  );

  assign m_tuser = res.kind;
  assign m_tlast = res.last;
  assign m_tdata = {5'd0, res.entry_bytes, res.entry_mac, res.entry_ip, res.entry_slot,
                    res.dst_slot, res.src_slot, res.dst_status, res.src_status};

endmodule

### design/htat_checker.sv
// Port-level checks on the result channel of the host traffic accounting table.
// Uses htat_pkg and is bound to host_traffic_accounting_table.
module htat_port_checks (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata,
  input logic [1:0]   m_tuser,
  input logic         m_tlast
);
  import htat_pkg::*;

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result beat changed");

  // A packet result is always the only beat of its input.
  a_pkt_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_PKT) |-> m_tlast)
    else $error("packet result without last");

  // An empty window beat carries nothing else and ends the dump.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_EMPTY) |-> m_tlast && (m_tdata == '0))
    else $error("empty window beat not clean");

  // Report beats carry no lookup status or slots.
  a_report: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == KIND_SRC) || (m_tuser == KIND_DST)) |-> (m_tdata[13:0] == '0))
    else $error("report beat with lookup fields set");

  // No result beat right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind host_traffic_accounting_table htat_port_checks u_htat_port_checks (.*);
